// ===== rtl/jca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick cursor accelerator package
// Shared word layouts, register map, request codes and arithmetic constants.
// ----------------------------------------------------------------------------
package jca_pkg;

   // Request codes
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_AXIS = 2'd1;
   localparam logic [1:0] REQ_MOVE = 2'd2;

   // Axis select codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   // Register map
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT_X      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT_Y      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEAD_ZONE    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANALOG_MODE  = 3'd4;

   // Register reset values
   localparam logic [15:0] DELAY_RESET     = 16'd25;
   localparam logic [14:0] DEAD_ZONE_RESET = 15'd3200;

   // Ramp states
   localparam logic [1:0] RAMP_OFF   = 2'd0;
   localparam logic [1:0] RAMP_ARMED = 2'd1;
   localparam logic [1:0] RAMP_RUN   = 2'd2;

   // Velocity limits and ramp constants
   localparam logic signed [11:0] VEL_MAX  = 12'sd2047;
   localparam logic signed [11:0] JUMP_VEL = 12'sd5;
   localparam logic signed [11:0] VEL_ONE  = 12'sd1;
   localparam int RAMP_FAST = 12;
   localparam int RAMP_JUMP = 8;

   // Analog divide by 2000: multiply by rounded-up reciprocal, exact for magnitudes up to 32768
   localparam int ANALOG_DIV = 2000;
   localparam int DIV_SHIFT  = 26;
   localparam int DIV_RECIP  = ((2 ** DIV_SHIFT) + ANALOG_DIV - 1) / ANALOG_DIV;

   typedef struct packed {
      logic        [1:0]  req_type;
      logic        [31:0] now_ms;
      logic        [1:0]  axis_sel;
      logic signed [15:0] axis_value;
      logic        [14:0] pos_x;
      logic        [14:0] pos_y;
   } req_word_type;

   typedef struct packed {
      logic [14:0] cursor_x;
      logic [14:0] cursor_y;
      logic        warp;
      logic        motion_event;
   } rsp_word_type;

endpackage

// ===== rtl/jca_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick cursor accelerator stream channel
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface jca_stream_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/joystick_cursor_accelerator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick cursor accelerator core
// Converts joystick axis samples and millisecond ticks into a cursor position.
// ----------------------------------------------------------------------------
// The core takes one request word per cycle unless the response side stalls,
// and returns exactly one response word for each, in order. A word is held in
// the input register and then worked out in a single pass of logic against the
// cursor state, which is updated in the same edge that loads the response
// register. Sustained rate is one word per cycle without stalls, set by the
// single-pass update of the cursor state. A stalled response holds the response
// register, and the input register still takes one more word behind it. The
// user must write configuration through csr_we/csr_index/csr_wdata only while
// no word is in flight; the core does not enforce this. Indexes beyond the map
// are dropped.
module joystick_cursor_accelerator_core #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   jca_stream_if.sink                           req_ch,
   jca_stream_if.source                         rsp_ch,
   input  logic                                 csr_we,
   input  logic [jca_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [jca_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import jca_pkg::*;

   // Configuration registers
   logic [14:0] limit_ff [2];
   logic [15:0] delay_ff;
   logic [14:0] dead_zone_ff;
   logic        analog_ff;

   // Pipeline registers
   req_word_type req_word_ff;
   logic         req_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         rsp_valid_ff;
   logic         advance;

   // Cursor state, index 0 is x and 1 is y
   logic        [14:0]           cur_ff  [2];
   logic        [14:0]           cur_in  [2];
   logic signed [11:0]           vel_ff  [2];
   logic signed [11:0]           vel_in  [2];
   logic        [1:0]            ramp_ff [2];
   logic        [1:0]            ramp_in [2];
   logic        [TIME_WIDTH-1:0] held_ff [2];
   logic        [TIME_WIDTH-1:0] held_in [2];
   logic        [TIME_WIDTH-1:0] last_step_ff, last_step_in;

   // ------------------------------------------------------------------------
   // Handshake: the input register advances whenever the response register
   // is free or being emptied this cycle.
   // ------------------------------------------------------------------------
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !req_valid_ff || advance;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= (req_ch.valid && req_ch.ready) || (req_valid_ff && !advance);
         rsp_valid_ff <= advance || (rsp_valid_ff && !rsp_ch.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         req_word_ff <= req_ch.data;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // ------------------------------------------------------------------------
   // Configuration writes
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff[0]  <= '0;
         limit_ff[1]  <= '0;
         delay_ff     <= DELAY_RESET;
         dead_zone_ff <= DEAD_ZONE_RESET;
         analog_ff    <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIMIT_X:      limit_ff[0]  <= csr_wdata[14:0];
            CSR_LIMIT_Y:      limit_ff[1]  <= csr_wdata[14:0];
            CSR_DELAY_PERIOD: delay_ff     <= csr_wdata;
            CSR_DEAD_ZONE:    dead_zone_ff <= csr_wdata[14:0];
            CSR_ANALOG_MODE:  analog_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Single-pass update
   // ------------------------------------------------------------------------
   always_comb begin
      logic        [TIME_WIDTH-1:0] now_t;
      logic        [TIME_WIDTH-1:0] dly_t;
      logic        [TIME_WIDTH-1:0] dly_fast;
      logic        [TIME_WIDTH-1:0] dly_jump;
      logic                         step_due;
      logic                         any_vel;
      logic        [1:0]            ramp_mid [2];
      logic        [TIME_WIDTH-1:0] held_mid [2];
      logic        [TIME_WIDTH-1:0] t_fast;
      logic        [TIME_WIDTH-1:0] t_jump;
      logic signed [12:0]           vel_step;
      logic signed [11:0]           vel_adj;
      logic signed [16:0]           pos_sum;
      logic signed [16:0]           axis_a;
      logic signed [16:0]           dz_s;
      logic signed [16:0]           a_dz;
      logic                         above;
      logic                         below;
      logic        [15:0]           mag;
      logic        [31:0]           prod;
      logic signed [11:0]           quot;
      logic signed [11:0]           vel_set;
      logic        [1:0]            ramp_set;

      // Hold state unless the request says otherwise
      for (int i = 0; i < 2; i++) begin
         cur_in[i]   = cur_ff[i];
         vel_in[i]   = vel_ff[i];
         ramp_in[i]  = ramp_ff[i];
         held_in[i]  = held_ff[i];
         ramp_mid[i] = ramp_ff[i];
         held_mid[i] = held_ff[i];
      end
      last_step_in = last_step_ff;
      t_fast       = '0;
      t_jump       = '0;
      vel_step     = '0;
      vel_adj      = '0;
      pos_sum      = '0;

      // Tick timing; all sums wrap at the time width
      now_t    = TIME_WIDTH'(req_word_ff.now_ms);
      dly_t    = TIME_WIDTH'(delay_ff);
      dly_fast = TIME_WIDTH'(20'(delay_ff) * 20'(RAMP_FAST));
      dly_jump = TIME_WIDTH'(20'(delay_ff) * 20'(RAMP_JUMP));
      step_due = now_t >= TIME_WIDTH'(last_step_ff + dly_t);
      any_vel  = (vel_ff[0] != '0) || (vel_ff[1] != '0);

      // Dead zone removal on the axis sample
      axis_a = 17'(req_word_ff.axis_value);
      dz_s   = $signed({2'b00, dead_zone_ff});
      above  = axis_a > dz_s;
      below  = axis_a < -dz_s;
      if (above) begin
         a_dz = axis_a - dz_s;
      end else if (below) begin
         a_dz = axis_a + dz_s;
      end else begin
         a_dz = '0;
      end

      // Analog velocity: magnitude times reciprocal, then restore the sign
      mag  = below ? 16'(-a_dz) : 16'(a_dz);
      prod = 32'(mag) * 32'(DIV_RECIP);
      quot = 12'($signed({1'b0, prod[30:DIV_SHIFT]}));
      if (analog_ff) begin
         vel_set  = below ? -quot : quot;
         ramp_set = RAMP_OFF;
      end else if (a_dz != '0) begin
         vel_set  = below ? -VEL_ONE : VEL_ONE;
         ramp_set = RAMP_ARMED;
      end else begin
         vel_set  = '0;
         ramp_set = RAMP_OFF;
      end

      rsp_word_in.warp         = 1'b0;
      rsp_word_in.motion_event = 1'b0;

      unique case (req_word_ff.req_type)
         REQ_TICK: begin
            if (step_due) begin
               last_step_in = now_t;
               // An armed ramp starts its hold timer at this step
               for (int i = 0; i < 2; i++) begin
                  ramp_mid[i] = (ramp_ff[i] == RAMP_ARMED) ? RAMP_RUN : ramp_ff[i];
                  held_mid[i] = (ramp_ff[i] == RAMP_ARMED) ? now_t : held_ff[i];
                  ramp_in[i]  = ramp_mid[i];
                  held_in[i]  = held_mid[i];
               end
               if (any_vel) begin
                  rsp_word_in.warp = 1'b1;
                  for (int i = 0; i < 2; i++) begin
                     t_fast = TIME_WIDTH'(held_mid[i] + dly_fast);
                     t_jump = TIME_WIDTH'(held_mid[i] + dly_jump);
                     // Zero velocity counts as negative on the ramp
                     vel_step = (vel_ff[i] > 12'sd0) ? 13'(vel_ff[i]) + 13'sd1
                                                     : 13'(vel_ff[i]) - 13'sd1;
                     if (ramp_mid[i] == RAMP_OFF) begin
                        vel_adj = vel_ff[i];
                     end else if (now_t > t_fast) begin
                        if (vel_step > 13'(VEL_MAX)) begin
                           vel_adj = VEL_MAX;
                        end else if (vel_step < -13'(VEL_MAX)) begin
                           vel_adj = -VEL_MAX;
                        end else begin
                           vel_adj = 12'(vel_step);
                        end
                     end else if (now_t > t_jump) begin
                        vel_adj = (vel_ff[i] > 12'sd0) ? JUMP_VEL : -JUMP_VEL;
                     end else begin
                        vel_adj = vel_ff[i];
                     end
                     // Move and clamp; an edge hit bounces to unit speed and re-arms
                     pos_sum = $signed({2'b00, cur_ff[i]}) + 17'(vel_adj);
                     if (pos_sum < 17'sd0) begin
                        cur_in[i]  = '0;
                        vel_in[i]  = -VEL_ONE;
                        ramp_in[i] = RAMP_ARMED;
                     end else if (pos_sum > $signed({2'b00, limit_ff[i]})) begin
                        cur_in[i]  = limit_ff[i];
                        vel_in[i]  = VEL_ONE;
                        ramp_in[i] = RAMP_ARMED;
                     end else begin
                        cur_in[i]  = pos_sum[14:0];
                        vel_in[i]  = vel_adj;
                     end
                  end
               end
            end
         end
         REQ_AXIS: begin
            rsp_word_in.motion_event = above || below;
            if (req_word_ff.axis_sel == AXIS_X) begin
               vel_in[0]  = vel_set;
               ramp_in[0] = ramp_set;
            end else if (req_word_ff.axis_sel == AXIS_Y) begin
               vel_in[1]  = vel_set;
               ramp_in[1] = ramp_set;
            end
         end
         REQ_MOVE: begin
            rsp_word_in.motion_event = 1'b1;
            cur_in[0] = req_word_ff.pos_x;
            cur_in[1] = req_word_ff.pos_y;
         end
         default: ;
      endcase

      rsp_word_in.cursor_x = cur_in[0];
      rsp_word_in.cursor_y = cur_in[1];
   end

   // Commit state in the edge that loads the response
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            cur_ff[i]  <= '0;
            vel_ff[i]  <= '0;
            ramp_ff[i] <= RAMP_OFF;
            held_ff[i] <= '0;
         end
         last_step_ff <= '0;
      end else if (advance) begin
         for (int i = 0; i < 2; i++) begin
            cur_ff[i]  <= cur_in[i];
            vel_ff[i]  <= vel_in[i];
            ramp_ff[i] <= ramp_in[i];
            held_ff[i] <= held_in[i];
         end
         last_step_ff <= last_step_in;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (req_valid_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("request side stalled while a stage was free");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word did not reach the response register");

   a_vel_in_range: assert property (@(posedge clock) disable iff (reset)
      (vel_ff[0] >= -VEL_MAX) && (vel_ff[1] >= -VEL_MAX))
      else $error("velocity escaped its saturation range");

   a_ramp_code: assert property (@(posedge clock) disable iff (reset)
      (ramp_ff[0] <= RAMP_RUN) && (ramp_ff[1] <= RAMP_RUN))
      else $error("ramp state took an unused code");

endmodule

// ===== tb/joystick_cursor_accelerator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick cursor accelerator core testbench
// Feeds tick, axis, pointer and unknown request words through the core under
// random source gaps and sink stalls, and checks every response word against
// an in-bench cursor model that tracks position, velocity and ramp state.
// ----------------------------------------------------------------------------
module joystick_cursor_accelerator_core_tb;
   import jca_pkg::*;

   // Codes the package leaves unnamed: a request type with no meaning and
   // the two axis numbers that move nothing.
   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam logic [1:0] AXIS_OTHER_A = 2'd2;
   localparam logic [1:0] AXIS_OTHER_B = 2'd3;

   // Cycles without any handshake before the run is declared hung.
   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   jca_stream_if #(.word_type(req_word_type)) req_ch ();
   jca_stream_if #(.word_type(rsp_word_type)) rsp_ch ();

   joystick_cursor_accelerator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Register copies seen by the cursor model.
   logic [14:0] cfg_limit_x;
   logic [14:0] cfg_limit_y;
   logic [15:0] cfg_delay;
   logic [14:0] cfg_dead_zone;
   logic        cfg_analog;

   // Cursor model state.
   logic        [15:0] cursor_x_st, cursor_y_st;
   logic signed [11:0] vel_x_st, vel_y_st;
   logic        [1:0]  ramp_x_st, ramp_y_st;
   logic        [31:0] held_x_st, held_y_st, last_step_st;

   // Response words still owed by the core, oldest first.
   rsp_word_type expected_cursor[$];

   // Millisecond clock handed out to tick words.
   logic [31:0] ms_now;

   // Handshake pressure controls.
   bit sender_gaps_on     = 1'b1;
   bit receiver_stalls_on = 1'b1;
   int hold_request       = 0;
   int hold_left          = 0;

   // Run bookkeeping.
   int words_sent      = 0;
   int results_checked = 0;
   int warps_seen      = 0;
   int motions_seen    = 0;
   int settings_count  = 0;
   int mismatches      = 0;

   // -------------------------------------------------------------------------
   // Cursor model
   // -------------------------------------------------------------------------

   // Ramp acceleration for one axis at a step: jump to +-5 after 8 periods
   // held, then grow by one each period after 12. Zero counts as negative.
   function automatic logic signed [11:0] accel_velocity(
      input logic signed [11:0] vel,
      input logic        [1:0]  ramp,
      input logic        [31:0] held,
      input logic        [31:0] now
   );
      logic [31:0] t_fast;
      logic [31:0] t_jump;
      int          grown;
      t_fast = held + 32'(cfg_delay) * 32'(RAMP_FAST);
      t_jump = held + 32'(cfg_delay) * 32'(RAMP_JUMP);
      if (ramp == RAMP_OFF) return vel;
      if (now > t_fast) begin
         grown = (vel > 0) ? int'(vel) + 1 : int'(vel) - 1;
         if (grown > int'(VEL_MAX)) grown = int'(VEL_MAX);
         if (grown < -int'(VEL_MAX)) grown = -int'(VEL_MAX);
         return 12'(grown);
      end
      if (now > t_jump) return (vel > 0) ? JUMP_VEL : -JUMP_VEL;
      return vel;
   endfunction

   // Move one axis by its velocity; an edge hit clamps, bounces the velocity
   // to one unit back inward and re-arms the ramp.
   function automatic void move_axis(
      inout logic        [15:0] pos,
      inout logic signed [11:0] vel,
      inout logic        [1:0]  ramp,
      input logic        [14:0] limit
   );
      int p;
      p = int'(pos) + int'(vel);
      if (p < 0) begin
         p    = 0;
         vel  = -VEL_ONE;
         ramp = RAMP_ARMED;
      end else if (p > int'(limit)) begin
         p    = int'(limit);
         vel  = VEL_ONE;
         ramp = RAMP_ARMED;
      end
      pos = 16'(p);
   endfunction

   // Velocity from a dead-zone corrected axis reading.
   function automatic void set_velocity(
      input int                 a,
      inout logic signed [11:0] vel,
      inout logic        [1:0]  ramp
   );
      if (cfg_analog) begin
         vel  = 12'(a / ANALOG_DIV);
         ramp = RAMP_OFF;
      end else if (a != 0) begin
         vel  = (a > 0) ? VEL_ONE : -VEL_ONE;
         ramp = RAMP_ARMED;
      end else begin
         vel  = '0;
         ramp = RAMP_OFF;
      end
   endfunction

   // Advance the model by one request word and return the response it owes.
   function automatic rsp_word_type predict_cursor(input req_word_type w);
      rsp_word_type r;
      logic [31:0]  due;
      int           a;
      int           dz;
      r = '0;
      case (w.req_type)
         REQ_TICK: begin
            due = last_step_st + 32'(cfg_delay);
            if (w.now_ms >= due) begin
               last_step_st = w.now_ms;
               if (ramp_x_st == RAMP_ARMED) begin
                  held_x_st = w.now_ms;
                  ramp_x_st = RAMP_RUN;
               end
               if (ramp_y_st == RAMP_ARMED) begin
                  held_y_st = w.now_ms;
                  ramp_y_st = RAMP_RUN;
               end
               if (vel_x_st != 0 || vel_y_st != 0) begin
                  vel_x_st = accel_velocity(vel_x_st, ramp_x_st, held_x_st, w.now_ms);
                  vel_y_st = accel_velocity(vel_y_st, ramp_y_st, held_y_st, w.now_ms);
                  move_axis(cursor_x_st, vel_x_st, ramp_x_st, cfg_limit_x);
                  move_axis(cursor_y_st, vel_y_st, ramp_y_st, cfg_limit_y);
                  r.warp = 1'b1;
               end
            end
         end
         REQ_AXIS: begin
            a  = int'($signed(w.axis_value));
            dz = int'(cfg_dead_zone);
            if (a > dz) begin
               a = a - dz;
               r.motion_event = 1'b1;
            end else if (a < -dz) begin
               a = a + dz;
               r.motion_event = 1'b1;
            end else begin
               a = 0;
            end
            if (w.axis_sel == AXIS_X) set_velocity(a, vel_x_st, ramp_x_st);
            else if (w.axis_sel == AXIS_Y) set_velocity(a, vel_y_st, ramp_y_st);
         end
         REQ_MOVE: begin
            cursor_x_st    = 16'(w.pos_x);
            cursor_y_st    = 16'(w.pos_y);
            r.motion_event = 1'b1;
         end
         default: ;
      endcase
      r.cursor_x = cursor_x_st[14:0];
      r.cursor_y = cursor_y_st[14:0];
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Word builders: every field starts random, then the meaningful ones are set
   // -------------------------------------------------------------------------

   function automatic req_word_type noise_word();
      req_word_type w;
      w.req_type   = 2'($urandom_range(3));
      w.now_ms     = $urandom;
      w.axis_sel   = 2'($urandom_range(3));
      w.axis_value = 16'($urandom_range(65535));
      w.pos_x      = 15'($urandom_range(32767));
      w.pos_y      = 15'($urandom_range(32767));
      return w;
   endfunction

   function automatic req_word_type tick_word(input logic [31:0] now);
      req_word_type w;
      w          = noise_word();
      w.req_type = REQ_TICK;
      w.now_ms   = now;
      return w;
   endfunction

   function automatic req_word_type axis_word(input logic [1:0] sel,
                                              input logic signed [15:0] value);
      req_word_type w;
      w            = noise_word();
      w.req_type   = REQ_AXIS;
      w.axis_sel   = sel;
      w.axis_value = value;
      return w;
   endfunction

   function automatic req_word_type move_word(input logic [14:0] x, input logic [14:0] y);
      req_word_type w;
      w          = noise_word();
      w.req_type = REQ_MOVE;
      w.pos_x    = x;
      w.pos_y    = y;
      return w;
   endfunction

   // Axis readings: four in ten fully random, the rest hugging the dead-zone edge,
   // the rails, or comfortably outside the dead zone.
   function automatic logic signed [15:0] pick_axis_value();
      int v;
      int dz;
      dz = int'(cfg_dead_zone);
      case ($urandom_range(9))
         0, 1, 2, 3: v = int'($signed(16'($urandom)));
         4, 5:       v = dz + int'($urandom_range(2)) - 1;
         6:          v = 32767;
         7:          v = -32768;
         default:    v = dz + int'($urandom_range(6000));
      endcase
      if ($urandom_range(99) < 20 && v > 0 && v < 32767) v = -v;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   function automatic logic [14:0] pick_position(input logic [14:0] limit);
      case ($urandom_range(9))
         0:       return 15'd0;
         1:       return 15'd32767;
         2:       return limit;
         default: return 15'($urandom_range(32767));
      endcase
   endfunction

   // Next tick time: mostly exactly one period on, sometimes early or late.
   function automatic logic [31:0] next_tick_time();
      if ($urandom_range(99) < 80) ms_now = ms_now + 32'(cfg_delay);
      else ms_now = ms_now + $urandom_range(2 * cfg_delay + 1);
      return ms_now;
   endfunction

   // -------------------------------------------------------------------------
   // Channel and register drivers
   // -------------------------------------------------------------------------

   // Offer one word, optionally after a random gap, and hold it until taken.
   // Enter and leave on a falling edge; valid stays high for the next word.
   task automatic send_word(input req_word_type w);
      if (sender_gaps_on) begin
         while ($urandom_range(99) < 30) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_cursor.push_back(predict_cursor(w));
      words_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait for every owed response, plus pipeline slack.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_cursor.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0]  value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_LIMIT_X:      cfg_limit_x   = value[14:0];
         CSR_LIMIT_Y:      cfg_limit_y   = value[14:0];
         CSR_DELAY_PERIOD: cfg_delay     = value;
         CSR_DEAD_ZONE:    cfg_dead_zone = value[14:0];
         CSR_ANALOG_MODE:  cfg_analog    = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [14:0] limit_x, input logic [14:0] limit_y,
                            input logic [15:0] delay, input logic [14:0] dead_zone,
                            input logic analog);
      write_reg(CSR_LIMIT_X,      16'(limit_x));
      write_reg(CSR_LIMIT_Y,      16'(limit_y));
      write_reg(CSR_DELAY_PERIOD, delay);
      write_reg(CSR_DEAD_ZONE,    16'(dead_zone));
      write_reg(CSR_ANALOG_MODE,  16'(analog));
      settings_count++;
   endtask

   // Random traffic under the current settings. Most of it is a press of one
   // or two axes followed by a run of ticks, often long enough to climb the ramp.
   task automatic run_traffic(input int count);
      int           sent;
      int           pick;
      int           run_len;
      logic [1:0]   sel;
      req_word_type w;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            sel = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
            send_word(axis_word(sel, pick_axis_value()));
            sent++;
            if ($urandom_range(1)) begin
               send_word(axis_word(~sel & 2'b01, pick_axis_value()));
               sent++;
            end
            run_len = $urandom_range(30, 5);
            repeat (run_len) begin
               send_word(tick_word(next_tick_time()));
               sent++;
            end
         end else if (pick < 68) begin
            send_word(move_word(pick_position(cfg_limit_x), pick_position(cfg_limit_y)));
            sent++;
         end else if (pick < 78) begin
            send_word(tick_word(next_tick_time()));
            sent++;
         end else if (pick < 88) begin
            send_word(axis_word(2'($urandom_range(3)), pick_axis_value()));
            sent++;
         end else if (pick < 94) begin
            w          = noise_word();
            w.req_type = REQ_UNUSED;
            send_word(w);
            sent++;
         end else begin
            // Time jumps anywhere, backward or across the wrap.
            ms_now = $urandom;
            send_word(tick_word(ms_now));
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Hand-picked words: rails, dead-zone edges, ignored axes, unknown request,
   // time wrap, lowered limits, zero period and the digital ramp jump.
   task automatic test_directed();
      req_word_type w;
      // Reset settings: limits zero, period 25, dead zone 3200, analog.
      send_word(axis_word(AXIS_X, 16'sd32767));
      send_word(axis_word(AXIS_Y, -16'sd32768));
      send_word(axis_word(AXIS_X, 16'sd3200));
      send_word(axis_word(AXIS_OTHER_A, -16'sd20000));
      send_word(axis_word(AXIS_OTHER_B, 16'sd20000));
      w          = noise_word();
      w.req_type = REQ_UNUSED;
      send_word(w);
      send_word(tick_word(32'd24));
      send_word(tick_word(32'd25));
      send_word(move_word(15'd12345, 15'd32767));

      // Full range, longest period, no dead zone; ticks straddle the wrap.
      drain_results();
      configure(15'd32767, 15'd32767, 16'd65535, 15'd0, 1'b1);
      send_word(axis_word(AXIS_X, 16'sd32767));
      send_word(axis_word(AXIS_Y, -16'sd32768));
      send_word(tick_word(32'hFFFF_FFF0));
      send_word(tick_word(32'hFFFF_FFFF));
      send_word(tick_word(32'd5));
      send_word(move_word(15'd32767, 15'd0));
      send_word(tick_word(32'd65534));

      // Limits lowered under a cursor that sits beyond them; zero period;
      // widest dead zone in digital mode.
      drain_results();
      configure(15'd100, 15'd0, 16'd0, 15'd32767, 1'b0);
      send_word(move_word(15'd30000, 15'd20000));
      send_word(axis_word(AXIS_X, 16'sd32767));
      send_word(axis_word(AXIS_Y, -16'sd32768));
      send_word(tick_word(32'd65534));
      send_word(tick_word(32'd65535));

      // Digital ramp with a one millisecond period: hold, jump, then grow.
      drain_results();
      configure(15'd32767, 15'd32767, 16'd1, 15'd0, 1'b0);
      send_word(move_word(15'd16000, 15'd16000));
      send_word(axis_word(AXIS_X, 16'sd1));
      send_word(axis_word(AXIS_Y, 16'sd0));
      send_word(tick_word(32'd70000));
      send_word(tick_word(32'd70010));
      send_word(tick_word(32'd70020));
      ms_now = 32'd70020;
   endtask

   // Hold off the sink long enough for the core to fill and stall its input.
   task automatic test_backpressure();
      drain_results();
      configure(15'd2000, 15'd1500, 16'd3, 15'd1000, 1'b0);
      hold_request = 300;
      run_traffic(40);
      drain_results();
   endtask

   // Back-to-back words with neither side idling.
   task automatic test_full_rate();
      drain_results();
      configure(15'd32767, 15'd32767, 16'd2, 15'd3200, 1'b1);
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      run_traffic(150);
      drain_results();
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
   endtask

   // Several random register settings, each with its own traffic phase.
   task automatic test_random_phases(input int phases, input int per_phase);
      logic [14:0] lim_x, lim_y, dz;
      logic [15:0] delay;
      repeat (phases) begin
         drain_results();
         case ($urandom_range(3))
            0: lim_x = 15'd0;
            1: lim_x = 15'd32767;
            2: lim_x = 15'($urandom_range(300));
            default: lim_x = 15'($urandom_range(32767));
         endcase
         case ($urandom_range(3))
            0: lim_y = 15'd0;
            1: lim_y = 15'd32767;
            2: lim_y = 15'($urandom_range(300));
            default: lim_y = 15'($urandom_range(32767));
         endcase
         case ($urandom_range(9))
            0: delay = 16'd0;
            1: delay = 16'd65535;
            2, 3: delay = 16'd1;
            default: delay = 16'($urandom_range(40, 2));
         endcase
         case ($urandom_range(4))
            0: dz = 15'd0;
            1: dz = 15'd32767;
            2: dz = 15'd3200;
            default: dz = 15'($urandom_range(12000));
         endcase
         configure(lim_x, lim_y, delay, dz, 1'($urandom_range(1)));
         // Restart the millisecond clock now and then, near the wrap too.
         case ($urandom_range(4))
            0: ms_now = $urandom;
            1: ms_now = 32'hFFFF_FFFF - $urandom_range(2000);
            default: ;
         endcase
         run_traffic(per_phase);
      end
   endtask

   // -------------------------------------------------------------------------
   // Sink: random stalls, plus a long hold-off counted here on request
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (receiver_stalls_on) begin
         rsp_ch.ready <= ($urandom_range(99) >= 30);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Response checker: compare each taken word with the oldest expectation
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_cursor.size() == 0) begin
            $display("%0t: response word with nothing owed: %p", $time, rsp_ch.data);
            mismatches++;
         end else begin
            want = expected_cursor.pop_front();
            results_checked++;
            if (want.warp) warps_seen++;
            if (want.motion_event) motions_seen++;
            if (rsp_ch.data.cursor_x !== want.cursor_x) begin
               $display("%0t: cursor_x expected %0d actual %0d",
                        $time, want.cursor_x, rsp_ch.data.cursor_x);
               mismatches++;
            end
            if (rsp_ch.data.cursor_y !== want.cursor_y) begin
               $display("%0t: cursor_y expected %0d actual %0d",
                        $time, want.cursor_y, rsp_ch.data.cursor_y);
               mismatches++;
            end
            if (rsp_ch.data.warp !== want.warp) begin
               $display("%0t: warp expected %0b actual %0b",
                        $time, want.warp, rsp_ch.data.warp);
               mismatches++;
            end
            if (rsp_ch.data.motion_event !== want.motion_event) begin
               $display("%0t: motion_event expected %0b actual %0b",
                        $time, want.motion_event, rsp_ch.data.motion_event);
               mismatches++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run if no word moves on either channel for too long
   // -------------------------------------------------------------------------
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      wait (!reset);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: timeout, no word moved for %0d cycles, %0d responses owed",
               $time, STALL_LIMIT, expected_cursor.size());
      $display("FAIL joystick_cursor_accelerator_core");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      // Drive the sender and register inputs to known values before the
      // first edge; the sink process owns ready.
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      ms_now       = '0;

      // Model state and registers as they come out of reset.
      cfg_limit_x   = '0;
      cfg_limit_y   = '0;
      cfg_delay     = DELAY_RESET;
      cfg_dead_zone = DEAD_ZONE_RESET;
      cfg_analog    = 1'b1;
      cursor_x_st   = '0;
      cursor_y_st   = '0;
      vel_x_st      = '0;
      vel_y_st      = '0;
      ramp_x_st     = RAMP_OFF;
      ramp_y_st     = RAMP_OFF;
      held_x_st     = '0;
      held_y_st     = '0;
      last_step_st  = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_backpressure();
      test_full_rate();
      test_random_phases(9, 125);
      drain_results();
      repeat (8) @(posedge clock);

      $display("Covered %0d words over %0d register settings; %0d responses checked.",
               words_sent, settings_count, results_checked);
      $display("Cursor moved on %0d ticks, motion flagged on %0d words, %0d mismatches.",
               warps_seen, motions_seen, mismatches);
      if (mismatches == 0)
         $display("PASS joystick_cursor_accelerator_core");
      else
         $display("FAIL joystick_cursor_accelerator_core");
      $finish;
   end

endmodule
